// ----- rtl/spq_pkg.sv -----
// spq_pkg: shared sizes, codes and control types of the stable priority queue
// used by spq_ctrl, spq_datapath and stable_priority_queue
// no dependencies
package spq_pkg;

   localparam int DEPTH          = 16;
   localparam int TAG_BITS       = 32;
   localparam int PRIORITY_BITS  = 16;
   localparam int COUNT_BITS     = $clog2(DEPTH + 1);
   localparam int OCC_BITS       = 5;
   localparam int STATUS_BITS    = 2;
   localparam int REQ_TDATA_BITS = ((TAG_BITS + PRIORITY_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((TAG_BITS + PRIORITY_BITS + OCC_BITS + 7) / 8) * 8;

   // request kind carried in req_tuser
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } spq_op_type;

   // result status carried in rsp_tuser
   typedef enum logic [STATUS_BITS-1:0] {
      ST_INSERTED = 2'd0,
      ST_REMOVED  = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } spq_status_type;

   // datapath action chosen by the controller
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_INSERT,
      CMD_REMOVE,
      CMD_REJECT_FULL,
      CMD_REPORT_EMPTY
   } spq_action_type;

   typedef enum logic {
      STATE_IDLE,
      STATE_EXEC
   } spq_state_type;

   // controller to datapath
   typedef struct packed {
      logic           load;
      spq_action_type action;
   } spq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_remove;
      logic is_full;
      logic is_empty;
   } spq_stat_type;

endpackage

// ----- rtl/spq_ctrl.sv -----
// spq_ctrl: handshake and sequencing state machine of the stable priority queue
// depends on spq_pkg
module spq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  spq_pkg::spq_stat_type stat,
   output spq_pkg::spq_cmd_type  cmd
);
   import spq_pkg::*;

   spq_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // state and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      req_tready   = 1'b0;
      cmd.load     = 1'b0;
      cmd.action   = CMD_NONE;
      case (state_ff)
         STATE_IDLE: begin
            // no request transfer while reset is held
            if (!reset) begin
               req_tready = 1'b1;
               if (req_tvalid) begin
                  cmd.load = 1'b1;
                  state_in = STATE_EXEC;
               end
            end
         end
         STATE_EXEC: begin
            // commit only when the result register is free or being drained
            if (!rsp_valid_ff || rsp_tready) begin
               if (stat.is_remove) begin
                  cmd.action = stat.is_empty ? CMD_REPORT_EMPTY : CMD_REMOVE;
               end else begin
                  cmd.action = stat.is_full ? CMD_REJECT_FULL : CMD_INSERT;
               end
               rsp_valid_in = 1'b1;
               state_in     = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- rtl/spq_datapath.sv -----
// spq_datapath: sorted entry row with parallel compare and shift, request and result registers
// depends on spq_pkg
module spq_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_operation,
   input  logic [spq_pkg::TAG_BITS-1:0]           req_payload,
   input  logic signed [spq_pkg::PRIORITY_BITS-1:0] req_priority,
   input  spq_pkg::spq_cmd_type                   cmd,
   output spq_pkg::spq_stat_type                  stat,
   output logic [spq_pkg::STATUS_BITS-1:0]        rsp_status,
   output logic [spq_pkg::TAG_BITS-1:0]           rsp_payload,
   output logic signed [spq_pkg::PRIORITY_BITS-1:0] rsp_priority,
   output logic [spq_pkg::OCC_BITS-1:0]           rsp_occupancy
);
   import spq_pkg::*;

   logic                            op_ff;
   logic [TAG_BITS-1:0]             new_tag_ff;
   logic signed [PRIORITY_BITS-1:0] new_pri_ff;

   logic [COUNT_BITS-1:0]           count_ff, count_in;
   logic [TAG_BITS-1:0]             ent_tag_ff [DEPTH];
   logic [TAG_BITS-1:0]             ent_tag_in [DEPTH];
   logic signed [PRIORITY_BITS-1:0] ent_pri_ff [DEPTH];
   logic signed [PRIORITY_BITS-1:0] ent_pri_in [DEPTH];
   logic [DEPTH-1:0]                keep;

   logic [STATUS_BITS-1:0]          status_ff, status_in;
   logic [TAG_BITS-1:0]             out_tag_ff, out_tag_in;
   logic signed [PRIORITY_BITS-1:0] out_pri_ff, out_pri_in;
   logic [OCC_BITS-1:0]             occ_ff, occ_in;

   // request register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_operation;
         new_tag_ff <= req_payload;
         new_pri_ff <= req_priority;
      end
   end

   // status towards the controller
   always_comb begin
      stat.is_remove = (op_ff == OP_REMOVE);
      stat.is_full   = (count_ff == COUNT_BITS'(DEPTH));
      stat.is_empty  = (count_ff == '0);
   end

   // per-entry compare: a valid entry of equal or higher priority stays put
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         keep[i] = (COUNT_BITS'(i) < count_ff) && (ent_pri_ff[i] >= new_pri_ff);
      end
   end

   // entry cells: insert shifts the tail down, remove shifts everything up
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ent_tag_in[i] = ent_tag_ff[i];
         ent_pri_in[i] = ent_pri_ff[i];
         if (cmd.action == CMD_INSERT && !keep[i]) begin
            if (i == 0) begin
               ent_tag_in[i] = new_tag_ff;
               ent_pri_in[i] = new_pri_ff;
            end else if (keep[(i == 0) ? 0 : i - 1]) begin
               ent_tag_in[i] = new_tag_ff;
               ent_pri_in[i] = new_pri_ff;
            end else begin
               ent_tag_in[i] = ent_tag_ff[(i == 0) ? 0 : i - 1];
               ent_pri_in[i] = ent_pri_ff[(i == 0) ? 0 : i - 1];
            end
         end else if (cmd.action == CMD_REMOVE && i != DEPTH - 1) begin
            ent_tag_in[i] = ent_tag_ff[(i == DEPTH - 1) ? i : i + 1];
            ent_pri_in[i] = ent_pri_ff[(i == DEPTH - 1) ? i : i + 1];
         end
      end
   end

   // entry registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         ent_tag_ff[i] <= ent_tag_in[i];
         ent_pri_ff[i] <= ent_pri_in[i];
      end
   end

   // fill count and result values
   always_comb begin
      count_in   = count_ff;
      status_in  = status_ff;
      out_tag_in = out_tag_ff;
      out_pri_in = out_pri_ff;
      case (cmd.action)
         CMD_INSERT: begin
            count_in  = count_ff + 1'b1;
            status_in = ST_INSERTED;
         end
         CMD_REMOVE: begin
            count_in  = count_ff - 1'b1;
            status_in = ST_REMOVED;
         end
         CMD_REJECT_FULL: begin
            status_in = ST_FULL;
         end
         CMD_REPORT_EMPTY: begin
            status_in = ST_EMPTY;
         end
         default: begin
         end
      endcase
      if (cmd.action != CMD_NONE) begin
         out_tag_in = (cmd.action == CMD_REMOVE) ? ent_tag_ff[0] : '0;
         out_pri_in = (cmd.action == CMD_REMOVE) ? ent_pri_ff[0] : '0;
      end
      occ_in = (cmd.action != CMD_NONE) ? OCC_BITS'(count_in) : occ_ff;
   end

   // count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      out_tag_ff <= out_tag_in;
      out_pri_ff <= out_pri_in;
      occ_ff     <= occ_in;
   end

   assign rsp_status    = status_ff;
   assign rsp_payload   = out_tag_ff;
   assign rsp_priority  = out_pri_ff;
   assign rsp_occupancy = occ_ff;

endmodule

// ----- rtl/stable_priority_queue.sv -----
// stable_priority_queue: sorted-list priority queue, ties leave first-in first-out
// depends on spq_pkg, spq_ctrl and spq_datapath
// A result becomes valid after its request has passed the request register and EXEC state,
// which waits while an earlier result is held; its transfer waits longer if rsp_tready is low.
// No request is taken before the last one commits; all entries compare and shift at once.
// Reset (synchronous, active high) empties the queue and clears both handshakes at once;
// stored entries are not cleared, so there is no clearing pass.
module stable_priority_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [spq_pkg::REQ_TDATA_BITS-1:0]   req_tdata,  // payload, priority_req
   input  logic                                 req_tuser,  // operation
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [spq_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,  // out_payload, out_priority, occupancy
   output logic [spq_pkg::STATUS_BITS-1:0]      rsp_tuser   // status
);
   import spq_pkg::*;

   spq_cmd_type                     cmd;
   spq_stat_type                    stat;
   logic [TAG_BITS-1:0]             rsp_payload;
   logic signed [PRIORITY_BITS-1:0] rsp_priority;
   logic [OCC_BITS-1:0]             rsp_occupancy;

   // sequencing
   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // entry storage and result values
   spq_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_tuser),
      .req_payload   (req_tdata[TAG_BITS-1:0]),
      .req_priority  (req_tdata[TAG_BITS+PRIORITY_BITS-1:TAG_BITS]),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_status    (rsp_tuser),
      .rsp_payload   (rsp_payload),
      .rsp_priority  (rsp_priority),
      .rsp_occupancy (rsp_occupancy)
   );

   // pack the result transfer, zero padding on top
   assign rsp_tdata = RSP_TDATA_BITS'({rsp_occupancy, rsp_priority, rsp_payload});

endmodule

// ----- verif/spq_checker.sv -----
// spq_checker: watches both channels of stable_priority_queue and predicts every result
// from its own copy of the sorted entry list, then compares it field by field
// depends on spq_pkg
module spq_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [spq_pkg::REQ_TDATA_BITS-1:0] req_tdata,  // payload, priority_req
   input  logic                               req_tuser,  // operation
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [spq_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,  // out_payload, out_priority, occupancy
   input  logic [spq_pkg::STATUS_BITS-1:0]    rsp_tuser,  // status
   output int                                 error_count,
   output int                                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import spq_pkg::*;

   typedef struct packed {
      spq_status_type                   status;
      logic [TAG_BITS-1:0]              tag;
      logic signed [PRIORITY_BITS-1:0]  prio;
      logic [OCC_BITS-1:0]              occupancy;
   } queue_result_type;

   // predicted contents of the queue, head first
   logic [TAG_BITS-1:0]             held_tag [DEPTH];
   logic signed [PRIORITY_BITS-1:0] held_prio [DEPTH];
   int                              held_count;

   queue_result_type expected_results [$];
   int               mismatches = 0;

   assign error_count = mismatches;

   // apply one request to the predicted list and work out its result
   task automatic predict_request(input spq_op_type op,
                                  input logic [TAG_BITS-1:0] tag,
                                  input logic signed [PRIORITY_BITS-1:0] prio,
                                  output queue_result_type res);
      int pos;
      int i;
      res = '0;
      if (op == OP_INSERT) begin
         if (held_count >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            // new entry goes behind every entry of equal or higher priority
            pos = 0;
            while (pos < held_count && held_prio[pos] >= prio) pos++;
            for (i = held_count; i > pos; i--) begin
               held_tag[i]  = held_tag[i-1];
               held_prio[i] = held_prio[i-1];
            end
            held_tag[pos]  = tag;
            held_prio[pos] = prio;
            held_count++;
            res.status = ST_INSERTED;
         end
      end else begin
         if (held_count == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.tag    = held_tag[0];
            res.prio   = held_prio[0];
            for (i = 1; i < held_count; i++) begin
               held_tag[i-1]  = held_tag[i];
               held_prio[i-1] = held_prio[i];
            end
            held_count--;
            res.status = ST_REMOVED;
         end
      end
      res.occupancy = OCC_BITS'(held_count);
   endtask

   // sample both channels at each rising edge
   always @(posedge clock) begin
      queue_result_type predicted;
      queue_result_type seen;
      if (reset) begin
         held_count = 0;
         expected_results.delete();
      end else begin
         // result transfer against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            seen.status    = spq_status_type'(rsp_tuser);
            seen.tag       = rsp_tdata[TAG_BITS-1:0];
            seen.prio      = rsp_tdata[TAG_BITS +: PRIORITY_BITS];
            seen.occupancy = rsp_tdata[TAG_BITS+PRIORITY_BITS +: OCC_BITS];
            if (expected_results.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result with none expected: status %0d tag %h prio %0d occ %0d",
                           $realtime, seen.status, seen.tag, seen.prio, seen.occupancy);
               mismatches++;
            end else begin
               predicted = expected_results.pop_front();
               if (seen.status !== predicted.status || seen.tag !== predicted.tag ||
                   seen.prio !== predicted.prio || seen.occupancy !== predicted.occupancy) begin
                  if (mismatches < 10)
                     $display({"%0t: wrong result: expected status %0d tag %h prio %0d occ %0d,",
                               " got status %0d tag %h prio %0d occ %0d"},
                              $realtime, predicted.status, predicted.tag, predicted.prio,
                              predicted.occupancy, seen.status, seen.tag, seen.prio,
                              seen.occupancy);
                  mismatches++;
               end
            end
         end
         // request transfer feeds the predictor
         if (req_tvalid && req_tready) begin
            predict_request(spq_op_type'(req_tuser), req_tdata[TAG_BITS-1:0],
                            req_tdata[TAG_BITS +: PRIORITY_BITS], predicted);
            expected_results.push_back(predicted);
         end
      end
      pending_count <= expected_results.size();
   end

endmodule

// ----- verif/testbench.sv -----
// testbench: drives stable_priority_queue with directed and random insert/remove traffic
// depends on spq_pkg, stable_priority_queue and spq_checker
// the checker does all prediction and comparison; this module makes stimulus and the verdict
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import spq_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int BLOCK_ITEMS    = 100;
   localparam int RANDOM_BLOCKS  = 19;
   localparam int QUIET_BLOCKS   = 2;
   localparam logic signed [PRIORITY_BITS-1:0] PRIO_MAX = {1'b0, {(PRIORITY_BITS-1){1'b1}}};
   localparam logic signed [PRIORITY_BITS-1:0] PRIO_MIN = {1'b1, {(PRIORITY_BITS-1){1'b0}}};

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;   // payload, priority_req
   logic                      req_tuser  = 1'b0; // operation
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;         // out_payload, out_priority, occupancy
   logic [STATUS_BITS-1:0]    rsp_tuser;         // status

   bit idling      = 1'b0;
   int stall_left  = 0;
   int quiet_count = 0;
   int error_count;
   int pending_count;

   // priorities for the directed fill: extremes and several ties
   logic signed [PRIORITY_BITS-1:0] fill_prio [DEPTH] = '{
      PRIO_MIN, PRIO_MAX, 16'sd0, -16'sd1, 16'sd1, 16'sd0, PRIO_MAX, PRIO_MIN,
      16'sd0, 16'sd5, -16'sd5, 16'sd1, -16'sd1, PRIO_MAX, 16'sd0, PRIO_MIN
   };

   stable_priority_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   spq_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // result side: stalls in random bursts while idling is on
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_count <= 0;
      end else if (quiet_count >= WATCHDOG_LIMIT) begin
         $display("stable_priority_queue: mismatch");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   // one request transfer, then perhaps a gap
   task automatic send_request(input spq_op_type op, input logic [TAG_BITS-1:0] tag,
                               input logic signed [PRIORITY_BITS-1:0] prio);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {prio, tag};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // random request; narrow priorities give plenty of ties
   task automatic send_random(input int insert_pct);
      logic signed [PRIORITY_BITS-1:0] prio;
      spq_op_type                      op;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: prio = PRIORITY_BITS'(int'($urandom_range(0, 6)) - 3);
         5:             prio = $urandom_range(0, 1) ? PRIO_MAX : PRIO_MIN;
         default:       prio = PRIORITY_BITS'($urandom);
      endcase
      op = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_REMOVE;
      send_request(op, $urandom, prio);
   endtask

   initial begin
      int insert_pct;
      repeat (5) @(posedge clock);
      reset  <= 1'b0;
      idling <= 1'b1;
      @(posedge clock);

      // directed: remove when empty, fill with extremes and ties, insert when full, then partly drain
      send_request(OP_REMOVE, '1, PRIO_MAX);
      for (int i = 0; i < DEPTH; i++)
         send_request(OP_INSERT, (i == 0) ? '0 : (i == 1) ? '1 : $urandom, fill_prio[i]);
      send_request(OP_INSERT, 32'h5a5a_a5a5, PRIO_MAX);
      repeat (7) send_request(OP_REMOVE, $urandom, PRIORITY_BITS'($urandom));

      // random blocks that lean towards filling, draining or neither
      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         case ($urandom_range(0, 2))
            0:       insert_pct = 25;
            1:       insert_pct = 50;
            default: insert_pct = 75;
         endcase
         idling <= (blk < RANDOM_BLOCKS - QUIET_BLOCKS) && ($urandom_range(0, 3) != 0);
         repeat (BLOCK_ITEMS) send_random(insert_pct);
      end

      // drain and give the verdict
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("stable_priority_queue: match");
      end else begin
         $display("stable_priority_queue: mismatch");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/stable_priority_queue.sv
verif/spq_checker.sv
verif/testbench.sv
